/* rtl/core/lpsd_pkg.sv */
// Shared types, constants and keyword tables for the sentence deframer.
`timescale 1ns / 1ps
`default_nettype none
package lpsd_pkg;

	// Word length field width; decoded lengths saturate at 2^LENGTH_BITS-1.
	localparam int LENGTH_BITS = 32;
	localparam logic [31:0] LEN_LIMIT = 32'((64'd1 << LENGTH_BITS) - 64'd1);

	localparam int KW_NUM  = 4;
	localparam int KW_CHARS = 6;

	// Reply type codes
	localparam logic [2:0] REPLY_DONE  = 3'd0;
	localparam logic [2:0] REPLY_RE    = 3'd1;
	localparam logic [2:0] REPLY_TRAP  = 3'd2;
	localparam logic [2:0] REPLY_FATAL = 3'd3;
	localparam logic [2:0] REPLY_NONE  = 3'd4;

	// Prefix byte counts still expected after the marker byte
	localparam logic [2:0] PFX_LEFT_2B = 3'd1;
	localparam logic [2:0] PFX_LEFT_3B = 3'd2;
	localparam logic [2:0] PFX_LEFT_4B = 3'd3;
	localparam logic [2:0] PFX_LEFT_5B = 3'd4;

	localparam logic [7:0] KW_TEXT [KW_NUM][KW_CHARS] = '{
		'{8'h21, 8'h64, 8'h6F, 8'h6E, 8'h65, 8'h00},  // !done
		'{8'h21, 8'h72, 8'h65, 8'h00, 8'h00, 8'h00},  // !re
		'{8'h21, 8'h74, 8'h72, 8'h61, 8'h70, 8'h00},  // !trap
		'{8'h21, 8'h66, 8'h61, 8'h74, 8'h61, 8'h6C}   // !fatal
	};
	localparam logic [31:0] KW_LEN [KW_NUM] = '{32'd5, 32'd3, 32'd5, 32'd6};

	typedef struct packed {
		logic [2:0]  prefix_left;
		logic [31:0] acc;
		logic [31:0] payload_left;
		logic        first_word;
		logic [2:0]  match_pos;
		logic [3:0]  match_cand;
		logic [2:0]  reply_kind;
	} state_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic        is_payload;
		logic        word_start;
		logic        word_end;
		logic        length_valid;
		logic [31:0] word_length;
		logic        sentence_end;
		logic [2:0]  reply_type;
	} result_t;

endpackage
`default_nettype wire

/* rtl/core/lpsd_if.sv */
// Valid/ready channel interfaces for the raw byte stream and the tagged result stream.
`timescale 1ns / 1ps
`default_nettype none
interface lpsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink   (input valid, input byte_in, output ready);
endinterface

interface lpsd_tag_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_out;
	logic        is_payload;
	logic        word_start;
	logic        word_end;
	logic        length_valid;
	logic [31:0] word_length;
	logic        sentence_end;
	logic [2:0]  reply_type;

	modport source (output valid, output byte_out, output is_payload, output word_start,
		output word_end, output length_valid, output word_length, output sentence_end,
		output reply_type, input ready);
	modport sink   (input valid, input byte_out, input is_payload, input word_start,
		input word_end, input length_valid, input word_length, input sentence_end,
		input reply_type, output ready);
endinterface
`default_nettype wire

/* rtl/core/lpsd_step.sv */
// Next-state and result logic for one stream byte.
`timescale 1ns / 1ps
`default_nettype none
module lpsd_step
	import lpsd_pkg::*;
(
	input  state_t     cur,
	input  logic [7:0] byte_in,
	output state_t     nxt,
	output result_t    res
);

	logic        complete;
	logic [31:0] acc_sat;

	always_comb begin
		nxt      = cur;
		complete = 1'b0;
		acc_sat  = '0;

		res              = '0;
		res.byte_out     = byte_in;
		res.reply_type   = REPLY_NONE;

		if (cur.payload_left != '0) begin
			res.is_payload = 1'b1;
			res.word_start = (cur.payload_left == cur.acc);
			if (cur.first_word) begin
				for (int i = 0; i < KW_NUM; i++) begin
					if (cur.match_pos >= 3'(KW_CHARS) || KW_TEXT[i][cur.match_pos] != byte_in) begin
						nxt.match_cand[i] = 1'b0;
					end
				end
				if (cur.match_pos != 3'd7) begin
					nxt.match_pos = cur.match_pos + 3'd1;
				end
			end
			nxt.payload_left = cur.payload_left - 32'd1;
			if (cur.payload_left == 32'd1) begin
				res.word_end = 1'b1;
				if (cur.first_word) begin
					// lowest surviving candidate wins
					nxt.reply_kind = REPLY_NONE;
					for (int i = KW_NUM - 1; i >= 0; i--) begin
						if (nxt.match_cand[i]) begin
							nxt.reply_kind = 3'(i);
						end
					end
					nxt.first_word = 1'b0;
				end
			end
		end else if (cur.prefix_left != '0) begin
			nxt.acc         = {cur.acc[23:0], byte_in};
			nxt.prefix_left = cur.prefix_left - 3'd1;
			complete        = (cur.prefix_left == 3'd1);
		end else begin
			if (!byte_in[7]) begin
				nxt.acc  = {24'd0, byte_in};
				complete = 1'b1;
			end else if (!byte_in[6]) begin
				nxt.acc         = {26'd0, byte_in[5:0]};
				nxt.prefix_left = PFX_LEFT_2B;
			end else if (!byte_in[5]) begin
				nxt.acc         = {27'd0, byte_in[4:0]};
				nxt.prefix_left = PFX_LEFT_3B;
			end else if (!byte_in[4]) begin
				nxt.acc         = {28'd0, byte_in[3:0]};
				nxt.prefix_left = PFX_LEFT_4B;
			end else begin
				// 0xF0 and the reserved markers above it: four full bytes follow
				nxt.acc         = '0;
				nxt.prefix_left = PFX_LEFT_5B;
			end
		end

		if (complete) begin
			acc_sat          = (nxt.acc > LEN_LIMIT) ? LEN_LIMIT : nxt.acc;
			nxt.acc          = acc_sat;
			res.length_valid = 1'b1;
			res.word_length  = acc_sat;
			if (acc_sat == '0) begin
				res.sentence_end = 1'b1;
				res.reply_type   = cur.reply_kind;
				nxt.first_word   = 1'b1;
				nxt.reply_kind   = REPLY_NONE;
				nxt.match_pos    = '0;
				nxt.match_cand   = '1;
			end else begin
				nxt.payload_left = acc_sat;
				if (cur.first_word) begin
					nxt.match_pos = '0;
					for (int i = 0; i < KW_NUM; i++) begin
						nxt.match_cand[i] = (KW_LEN[i] == acc_sat);
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/length_prefixed_sentence_deframer_core.sv */
// Top level: length-prefixed sentence deframer with input and result registers.
// An accepted item is held in the byte register and then in the result register,
// from which the tag channel takes it.
// Throughput: one item per cycle; the byte register and the result register
// advance together whenever the result register is empty or being taken.
// Reset: arst_n clears both valid flags and returns the parser to expecting a
// length prefix of the first word of a sentence, reply type none.
`timescale 1ns / 1ps
`default_nettype none
module length_prefixed_sentence_deframer_core
	import lpsd_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	lpsd_byte_if.sink    byte_ch,
	lpsd_tag_if.source   tag_ch
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       res_valid_q;
	result_t    res_q;
	state_t     state_q;
	state_t     state_d;
	result_t    res_d;
	logic       advance;

	assign advance       = valid_s1 && (!res_valid_q || tag_ch.ready);
	assign byte_ch.ready = !valid_s1 || advance;

	lpsd_step u_step (
		.cur     (state_q),
		.byte_in (byte_s1),
		.nxt     (state_d),
		.res     (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			byte_s1 <= byte_ch.byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			state_q     <= '{prefix_left: '0, acc: '0, payload_left: '0, first_word: 1'b1,
				match_pos: '0, match_cand: '1, reply_kind: REPLY_NONE};
		end else begin
			if (advance) begin
				res_valid_q <= 1'b1;
				state_q     <= state_d;
			end else if (tag_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign tag_ch.valid        = res_valid_q;
	assign tag_ch.byte_out     = res_q.byte_out;
	assign tag_ch.is_payload   = res_q.is_payload;
	assign tag_ch.word_start   = res_q.word_start;
	assign tag_ch.word_end     = res_q.word_end;
	assign tag_ch.length_valid = res_q.length_valid;
	assign tag_ch.word_length  = res_q.word_length;
	assign tag_ch.sentence_end = res_q.sentence_end;
	assign tag_ch.reply_type   = res_q.reply_type;

`ifndef SYNTHESIS
	a_payload_not_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.is_payload |-> !res_q.length_valid)
		else $error("payload item also flagged as length completion");
	a_end_is_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.sentence_end |-> res_q.length_valid && res_q.word_length == '0)
		else $error("sentence end without a zero length");
	a_body_excl_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.payload_left != '0 |-> state_q.prefix_left == '0)
		else $error("body and prefix counted at once");
	a_prefix_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.prefix_left <= PFX_LEFT_5B)
		else $error("prefix count out of range");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !tag_ch.ready |=> res_valid_q && $stable(res_q))
		else $error("stalled result lost or changed");
`endif

endmodule
`default_nettype wire
